// ===== rtl/pib_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the phase
// interferometer bearing block. No dependencies.
package pib_pkg;

    // Default parameter values
    localparam int PHASE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath width: holds 2^30 magnitudes grown by the CORDIC gain
    localparam int CW           = 34;
    localparam int ATAN_ENTRIES = 24;

    // Square root unit: 61-bit radicand, 31-bit root
    localparam int SQ_IN_W   = 61;
    localparam int SQ_ROOT_W = 31;

    // Wavelength over baseline after reset, unsigned Q16.16
    localparam logic [31:0] WOB_RESET = 32'd982359926;

    // Degrees in a turn times 256, and the largest bearing (90 degrees)
    localparam logic [31:0] DEG_SCALE = 32'd92160;
    localparam logic [14:0] ANGLE_MAX = 15'd23040;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHA_GO,
        S_PHA_WAIT,
        S_PHB_GO,
        S_PHB_WAIT,
        S_DIFF,
        S_MUL_P,
        S_SINE,
        S_MUL_S,
        S_SQ_GO,
        S_SQ_WAIT,
        S_ANG_GO,
        S_ANG_WAIT,
        S_MUL_A,
        S_FIN
    } t_state;

    // atan(2^-k) as a fraction of a turn, scaled by 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/phase_interferometer_bearing.sv =====
// Top level of the two-channel phase interferometer: sequencer, shared
// multiplier, held phases and stream ports. Depends on pib_pkg, pib_cordic
// and pib_isqrt.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: i_a, q_a, i_b, q_b
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: phase_diff, angle_deg;
//                                              tuser: in_range
//  cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_data: wavelength_over_base
//
// One item at a time. With both Q parts nonzero an item takes two phase
// CORDIC passes, the square root and the bearing CORDIC pass, one after
// another; the three CORDIC passes share the one CORDIC unit. Reusing held
// phases drops two passes; a sine above one skips the square root and bearing
// pass.
// Synchronous active-low reset clears control, held phases and output valid
// and loads the ratio with WOB_RESET; no clearing pass. A stalled output holds
// in the output register while the next item is taken in.
module phase_interferometer_bearing
    import pib_pkg::*;
#(
    parameter int PHASE_BITS   = PHASE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: i_a[15:0], q_a[31:16], i_b[47:32], q_b[63:48]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // tdata: phase_diff[PHASE_BITS:0], angle_deg (15 bits) above it, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((PHASE_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // tuser: in_range[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int DW   = PHASE_BITS + 1;              // phase_diff width
    localparam int TDW  = ((PHASE_BITS + 16 + 7) / 8) * 8;
    localparam int PW   = PHASE_BITS + 33;             // diff * wob width
    localparam int SFW  = PW + 5;                      // sine before clamp
    localparam int SR   = (PHASE_BITS > 14) ? PHASE_BITS - 14 : 0;
    localparam int SL   = (PHASE_BITS > 14) ? 0 : 14 - PHASE_BITS;
    localparam int RND  = (PHASE_BITS > 14) ? (1 << (PHASE_BITS - 15)) : 0;
    localparam int HALF = 1 << (31 - PHASE_BITS);      // phase rounding

    t_state r_state;
    t_state n_state;

    // Configuration and held state
    logic [31:0]           r_wob;
    logic [PHASE_BITS-1:0] r_held_a;
    logic [PHASE_BITS-1:0] r_held_b;

    // Captured samples
    logic signed [15:0] r_ia;
    logic signed [15:0] r_qa;
    logic signed [15:0] r_ib;
    logic signed [15:0] r_qb;

    // Working registers
    logic [DW-1:0]        r_diff;
    logic [63:0]          r_prod;
    logic                 r_ok;
    logic [30:0]          r_s30;
    logic [SQ_ROOT_W-1:0] r_c30;
    logic [31:0]          r_zpos;

    // Output register
    logic          r_m_valid;
    logic [DW-1:0] r_m_diff;
    logic [14:0]   r_m_angle;
    logic          r_m_ok;

    // Unit hookups
    logic                 cor_start;
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    logic                 cor_done;
    logic [31:0]          cor_z;
    logic                 sq_start;
    logic [SQ_IN_W-1:0]   sq_n;
    logic                 sq_done;
    logic [SQ_ROOT_W-1:0] sq_root;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;

    logic                  s_acc;
    logic                  both_nz;
    logic                  out_free;
    logic [32:0]           q_sum;
    logic [PHASE_BITS-1:0] ph_q;
    logic [PHASE_BITS-1:0] d_low;
    logic [SFW-1:0]        s_full;
    logic                  ok_now;
    logic [63:0]           ang_rnd;
    logic [14:0]           ang_fin;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign both_nz  = (s_axis_tdata[31:16] != 16'd0) && (s_axis_tdata[63:48] != 16'd0);
    assign out_free = !r_m_valid || m_axis_tready;

    // Round the CORDIC angle to PHASE_BITS, wrapping modulo one turn
    assign q_sum = {1'b0, cor_z} + 33'(HALF);
    assign ph_q  = q_sum[31:32-PHASE_BITS];

    // Phase difference, zero mapped to a full turn
    assign d_low = r_held_a - r_held_b;

    // Sine in Q30 from diff * wob, rounded half up, clamped to one
    assign s_full = ((SFW'(r_prod[PW-1:0]) + SFW'(RND)) >> SR) << SL;
    assign ok_now = (r_prod <= (64'd1 << (PHASE_BITS + 16)));

    // Bearing: round(z * 92160 / 2^32), clamped to 90 degrees
    assign ang_rnd = (r_prod + 64'h0000_0000_8000_0000) >> 32;
    assign ang_fin = (ang_rnd > 64'(ANGLE_MAX)) ? ANGLE_MAX : ang_rnd[14:0];

    // ---------------- Next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = both_nz ? S_PHA_GO : S_DIFF;
                end
            end
            S_PHA_GO:   n_state = S_PHA_WAIT;
            S_PHA_WAIT: if (cor_done) n_state = S_PHB_GO;
            S_PHB_GO:   n_state = S_PHB_WAIT;
            S_PHB_WAIT: if (cor_done) n_state = S_DIFF;
            S_DIFF:     n_state = S_MUL_P;
            S_MUL_P:    n_state = S_SINE;
            S_SINE:     n_state = ok_now ? S_MUL_S : S_FIN;
            S_MUL_S:    n_state = S_SQ_GO;
            S_SQ_GO:    n_state = S_SQ_WAIT;
            S_SQ_WAIT:  if (sq_done) n_state = S_ANG_GO;
            S_ANG_GO:   n_state = S_ANG_WAIT;
            S_ANG_WAIT: if (cor_done) n_state = S_MUL_A;
            S_MUL_A:    n_state = S_FIN;
            S_FIN:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------- Unit controls and operand selection ----------------
    always_comb begin
        cor_start = 1'b0;
        cor_x     = '0;
        cor_y     = '0;
        sq_start  = 1'b0;
        sq_n      = (SQ_IN_W'(1) << 60) - r_prod[SQ_IN_W-1:0];
        mul_a     = 32'(r_diff);
        mul_b     = r_wob;
        case (r_state)
            S_PHA_GO: begin
                cor_start = 1'b1;
                cor_x     = CW'($signed({r_qa, 8'h00}));
                cor_y     = CW'($signed({r_ia, 8'h00}));
            end
            S_PHB_GO: begin
                cor_start = 1'b1;
                cor_x     = CW'($signed({r_qb, 8'h00}));
                cor_y     = CW'($signed({r_ib, 8'h00}));
            end
            S_ANG_GO: begin
                cor_start = 1'b1;
                cor_x     = CW'(r_c30);
                cor_y     = CW'(r_s30);
            end
            S_SQ_GO: begin
                sq_start = 1'b1;
            end
            S_MUL_S: begin
                mul_a = 32'(r_s30);
                mul_b = 32'(r_s30);
            end
            S_MUL_A: begin
                mul_a = r_zpos;
                mul_b = DEG_SCALE;
            end
            default: begin
                mul_a = 32'(r_diff);
                mul_b = r_wob;
            end
        endcase
    end

    // ---------------- Control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wob     <= WOB_RESET;
            r_held_a  <= '0;
            r_held_b  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_wob <= i_cfg_data;
            end
            // Commit fresh phases as each CORDIC pass finishes
            if (r_state == S_PHA_WAIT && cor_done) begin
                r_held_a <= ph_q;
            end
            if (r_state == S_PHB_WAIT && cor_done) begin
                r_held_b <= ph_q;
            end
            if (r_state == S_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ---------------- Datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ia <= s_axis_tdata[15:0];
            r_qa <= s_axis_tdata[31:16];
            r_ib <= s_axis_tdata[47:32];
            r_qb <= s_axis_tdata[63:48];
        end
        if (r_state == S_DIFF) begin
            r_diff <= {(d_low == '0), d_low};
        end
        // Shared multiplier, registered
        if (r_state == S_MUL_P || r_state == S_MUL_S || r_state == S_MUL_A) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (r_state == S_SINE) begin
            r_ok  <= ok_now;
            r_s30 <= (s_full > (SFW'(1) << 30)) ? (31'd1 << 30) : s_full[30:0];
        end
        if (r_state == S_SQ_WAIT && sq_done) begin
            r_c30 <= sq_root;
        end
        // Negative bearings clamp to zero
        if (r_state == S_ANG_WAIT && cor_done) begin
            r_zpos <= cor_z[31] ? 32'd0 : cor_z;
        end
        if (r_state == S_FIN && out_free) begin
            r_m_diff  <= r_diff;
            r_m_ok    <= r_ok;
            r_m_angle <= r_ok ? ang_fin : 15'd0;
        end
    end

    // ---------------- Shared units ----------------
    pib_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .o_done  (cor_done),
        .o_z     (cor_z)
    );

    pib_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // ---------------- Ports ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = TDW'({r_m_angle, r_m_diff});
    assign m_axis_tuser  = r_m_ok;

    // ---------------- Assertions ----------------
    // CORDIC finishes only while the sequencer waits on it
    a_cor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == S_PHA_WAIT || r_state == S_PHB_WAIT ||
                      r_state == S_ANG_WAIT))
        else $error("CORDIC done outside a wait state");

    // Square root finishes only while the sequencer waits on it
    a_sq_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQ_WAIT))
        else $error("square root done outside its wait state");

    // Wrapped phase difference is never zero
    a_diff_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_m_diff != '0))
        else $error("phase difference of zero offered");

    // Out-of-range results carry a zero bearing
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_m_ok) |-> (r_m_angle == 15'd0))
        else $error("nonzero bearing with sine above one");

    // An accepted item leaves the idle state
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle after accepting an item");

endmodule

// ===== rtl/pib_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle out as a
// 32-bit fraction of a turn. Depends on pib_pkg.
module pib_cordic
    import pib_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_done,
    output logic [31:0]          o_z
);

    localparam int NS = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
    localparam int KW = $clog2(NS);

    logic                 r_busy;
    logic                 r_done;
    logic [KW-1:0]        r_k;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [31:0]          r_z;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [31:0]          at;

    assign xs = r_x >>> r_k;
    assign ys = r_y >>> r_k;
    assign at = atan_turn(5'(r_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == KW'(NS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // Datapath: pre-rotate into the right half plane, then rotate y toward zero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_x < 0) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= 32'h80000000;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

// ===== rtl/pib_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on pib_pkg.
module pib_isqrt
    import pib_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SQ_IN_W-1:0]   i_n,
    output logic                 o_done,
    output logic [SQ_ROOT_W-1:0] o_root
);

    localparam int NW  = 2 * SQ_ROOT_W;
    localparam int RMW = SQ_ROOT_W + 2;
    localparam int CNW = $clog2(SQ_ROOT_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNW-1:0]       r_cnt;
    logic [NW-1:0]        r_n;
    logic [RMW-1:0]       r_rem;
    logic [SQ_ROOT_W-1:0] r_root;

    logic [RMW+1:0]       rem_sh;
    logic [RMW+1:0]       trial;
    logic                 take;

    assign rem_sh = {r_rem, r_n[NW-1 -: 2]};
    assign trial  = (RMW + 2)'({r_root, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNW'(SQ_ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= NW'(i_n);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= r_n << 2;
            if (take) begin
                r_rem  <= RMW'(rem_sh - trial);
                r_root <= {r_root[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= RMW'(rem_sh);
                r_root <= {r_root[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== dv/pib_checker.sv =====
`timescale 1ns / 100ps
// Bearing checker for phase_interferometer_bearing: watches the sample, result
// and ratio channels, predicts every result and compares it. Depends on pib_pkg.
module pib_checker
    import pib_pkg::*;
#(
    parameter int PHASE_BITS   = PHASE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int RES_W        = ((PHASE_BITS + 16 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    // i_a, q_a, i_b, q_b from the lowest bit up
    input  logic [63:0]      i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    // phase_diff, angle_deg from the lowest bit up
    input  logic [RES_W-1:0] i_out_data,
    // in_range
    input  logic [0:0]       i_out_user,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [31:0]      i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    // atan(2^-k) in 2^32 units per turn
    localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [PHASE_BITS:0] diff;
        logic [14:0]         angle;
        logic                in_range;
    } t_bearing;

    t_bearing              bearing_q[$];
    logic [PHASE_BITS-1:0] phase_a;
    logic [PHASE_BITS-1:0] phase_b;
    logic [31:0]           ratio;
    int                    errors = 0;

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        errors++;
    endtask

    // Vectoring rotation: angle of (x0, y0) in 2^32 units per turn
    function automatic logic [31:0] vector_angle(input longint x0, input longint y0);
        longint      x, y, xs, ys;
        logic [31:0] z;
        x = x0;
        y = y0;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int k = 0; k < CORDIC_STEPS && k < ATAN_ENTRIES; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += ATAN_TURN[k];
            end else begin
                x -= ys;
                y += xs;
                z -= ATAN_TURN[k];
            end
        end
        return z;
    endfunction

    // Round half up to PHASE_BITS, wrapping modulo one turn
    function automatic logic [PHASE_BITS-1:0] round_phase(input logic [31:0] z);
        longint unsigned t;
        t = ({32'b0, z} + (64'd1 << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);
        return t[PHASE_BITS-1:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem, root, bit_v;
        rem   = n;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem) bit_v >>= 2;
        while (bit_v != 0) begin
            if (rem >= root + bit_v) begin
                rem  -= root + bit_v;
                root  = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    // Advance the held phases and work out the bearing of one sample pair
    function automatic t_bearing predict_bearing(input logic [63:0] d);
        longint          ia, qa, ib, qb;
        longint unsigned turn, diff, prod, s30, c30, a;
        logic [31:0]     z;
        t_bearing        r;
        ia   = longint'($signed(d[15:0]));
        qa   = longint'($signed(d[31:16]));
        ib   = longint'($signed(d[47:32]));
        qb   = longint'($signed(d[63:48]));
        turn = 64'd1 << PHASE_BITS;
        if (qa != 0 && qb != 0) begin
            phase_a = round_phase(vector_angle(qa * 256, ia * 256));
            phase_b = round_phase(vector_angle(qb * 256, ib * 256));
        end
        diff = (longint'(phase_a) - longint'(phase_b)) & (turn - 1);
        if (diff == 0) diff = turn;
        prod       = diff * ratio;
        r.diff     = diff[PHASE_BITS:0];
        r.in_range = (prod <= (64'd1 << (PHASE_BITS + 16)));
        r.angle    = '0;
        if (r.in_range) begin
            if (PHASE_BITS > 14)
                s30 = (prod + (64'd1 << (PHASE_BITS - 15))) >> (PHASE_BITS - 14);
            else
                s30 = prod << (14 - PHASE_BITS);
            if (s30 > (64'd1 << 30)) s30 = 64'd1 << 30;
            c30 = int_sqrt((64'd1 << 60) - s30 * s30);
            z   = vector_angle(longint'(c30), longint'(s30));
            if (!z[31]) begin
                a = ({32'b0, z} * DEG_SCALE + (64'd1 << 31)) >> 32;
                if (a > ANGLE_MAX) a = ANGLE_MAX;
                r.angle = a[14:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bearing want;
        if (!i_rst_n) begin
            ratio   = WOB_RESET;
            phase_a = '0;
            phase_b = '0;
            bearing_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) ratio = i_cfg_data;
            if (i_in_valid && i_in_ready) bearing_q.push_back(predict_bearing(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (bearing_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                              i_out_data, i_out_user));
                end else begin
                    want = bearing_q.pop_front();
                    if (i_out_data[PHASE_BITS:0] !== want.diff)
                        report_mismatch($sformatf("phase_diff got %0d want %0d",
                                                  i_out_data[PHASE_BITS:0], want.diff));
                    if (i_out_data[PHASE_BITS+15:PHASE_BITS+1] !== want.angle)
                        report_mismatch($sformatf("angle_deg got %0d want %0d (diff %0d)",
                                                  i_out_data[PHASE_BITS+15:PHASE_BITS+1],
                                                  want.angle, want.diff));
                    if (i_out_user[0] !== want.in_range)
                        report_mismatch($sformatf("in_range got %b want %b (diff %0d)",
                                                  i_out_user[0], want.in_range, want.diff));
                end
            end
        end
        o_errors  <= errors;
        o_pending <= bearing_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the bearing testbench: clock, reset, sample and ratio stimulus, result
// back-pressure and the verdict. Depends on pib_pkg, pib_checker and the block.
module tb;
    import pib_pkg::*;

    localparam int PHASE_BITS   = PHASE_BITS_DEF;
    localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
    localparam int RES_W        = ((PHASE_BITS + 16 + 7) / 8) * 8;
    // Rough cycle estimate for one item with fresh phases
    localparam int LAT          = 3 * CORDIC_STEPS + 45;
    localparam int SETTLE       = 2 * LAT;
    localparam int HOLD_CYCLES  = 2000;
    localparam int PHASE_ITEMS  = 125;
    localparam int LIMIT        = 1_000_000;

    typedef enum {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} t_pace;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic [63:0]      s_axis_tdata  = '0;
    logic             m_axis_tready = 1'b0;
    logic             i_cfg_valid   = 1'b0;
    logic [31:0]      i_cfg_data    = '0;
    logic             s_axis_tready;
    logic             m_axis_tvalid;
    logic [RES_W-1:0] m_axis_tdata;
    logic [0:0]       m_axis_tuser;
    logic             o_cfg_ready;

    logic             hold_req      = 1'b0;
    logic             rx_hold       = 1'b0;
    int               idle_pct      = 0;
    int               stall_pct     = 0;
    int               errors;
    int               pending;
    int unsigned      cycles        = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    phase_interferometer_bearing #(
        .PHASE_BITS   (PHASE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    pib_checker #(
        .PHASE_BITS   (PHASE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Result side: stall at random per cycle, and drop ready entirely while
    // the long hold-off is running.
    always @(posedge i_clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);

    // Long hold-off: once requested, hold the result side for a fixed stretch
    // while the sender keeps offering items, so the block backs up into its input.
    initial begin
        @(posedge hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_pace(input t_pace pace);
        idle_pct  = (pace == PACE_SENDER) ? 62 : (pace == PACE_BOTH) ? 11 : 0;
        stall_pct <= (pace == PACE_RECEIVER) ? 62 : (pace == PACE_BOTH) ? 11 : 0;
    endtask

    // Offer one item and hold it until the handshake. Valid stays high on
    // return so that a back-to-back item keeps it up without a dip; anything
    // that pauses must lower it first.
    task automatic send_item(input logic [63:0] d);
        int unsigned gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 2 * LAT) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_samples(input logic [15:0] ia, input logic [15:0] qa,
                                input logic [15:0] ib, input logic [15:0] qb);
        send_item({qb, ib, qa, ia});
    endtask

    // Drop valid and wait until every expected bearing has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Ratio writes only with the block idle: drain, let the datapath settle,
    // then hand the value over on the config channel.
    task automatic write_ratio(input logic [31:0] value);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] tiny_word();
        return 16'($urandom_range(8)) - 16'd4;
    endfunction

    // Mostly fresh pairs with nonzero Q; the rest exercise held phases,
    // equal phases, tiny vectors and the edges of the sample range.
    function automatic logic [63:0] random_samples();
        logic [15:0] ia, qa, ib, qb;
        int unsigned pick;
        ia   = 16'($urandom);
        qa   = 16'($urandom);
        ib   = 16'($urandom);
        qb   = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(2))
                0:       qa = '0;
                1:       qb = '0;
                default: begin qa = '0; qb = '0; end
            endcase
        end else if (pick < 18) begin
            ib = ia;
            qb = qa;
        end else if (pick < 25) begin
            ia = tiny_word();
            qa = tiny_word();
            ib = tiny_word();
            qb = tiny_word();
        end else if (pick < 30) begin
            ia = extreme_word();
            qa = extreme_word();
            ib = extreme_word();
            qb = extreme_word();
        end else begin
            if (qa == 0) qa = 16'd1;
            if (qb == 0) qb = 16'hFFFF;
        end
        return {qb, ib, qa, ia};
    endfunction

    // Corners of the sample range, zero Q on each side, equal phases
    task automatic run_corners();
        send_samples(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_samples(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_samples(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_samples(16'h0001, 16'h0000, 16'h0005, 16'h0007);
        send_samples(16'h0005, 16'h0007, 16'h0001, 16'h0000);
        send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_samples(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFF);
    endtask

    task automatic run_random(input int unsigned count, input t_pace pace,
                              input bit pause_mid, input bit hold_rx);
        set_pace(pace);
        for (int n = 0; n < count; n++) begin
            if (hold_rx && n == 4) hold_req <= 1'b1;
            if (pause_mid && n == count / 2) drain();
            send_item(random_samples());
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset ratio: nearly every difference puts the sine above one
        set_pace(PACE_FREE);
        run_corners();
        // Ratio of one: equal phases give a sine of exactly one
        write_ratio(32'd65536);
        run_corners();
        // Just above one for a full-turn difference
        write_ratio(32'd65537);
        send_samples(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_samples(16'h0064, 16'hFF38, 16'h0064, 16'hFF38);

        // Random phases across ratio settings and pacing
        write_ratio(32'd0);
        run_random(PHASE_ITEMS, PACE_FREE, 1'b0, 1'b0);
        write_ratio(32'd65536);
        run_random(PHASE_ITEMS, PACE_SENDER, 1'b1, 1'b0);
        write_ratio(32'hFFFF_FFFF);
        run_random(PHASE_ITEMS, PACE_RECEIVER, 1'b0, 1'b0);
        write_ratio(32'($urandom_range(16384, 200000)));
        run_random(PHASE_ITEMS, PACE_BOTH, 1'b0, 1'b1);
        write_ratio(32'd1);
        run_random(PHASE_ITEMS, PACE_FREE, 1'b0, 1'b0);
        write_ratio(32'd32768);
        run_random(PHASE_ITEMS, PACE_RECEIVER, 1'b0, 1'b0);
        write_ratio(WOB_RESET);
        run_random(PHASE_ITEMS, PACE_SENDER, 1'b0, 1'b0);
        write_ratio(32'($urandom_range(20000, 140000)));
        run_random(PHASE_ITEMS, PACE_BOTH, 1'b0, 1'b0);

        // Everything is in; let any stray result show up, then judge
        drain();
        repeat (2 * LAT) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pib_pkg.sv
rtl/pib_cordic.sv
rtl/pib_isqrt.sv
rtl/phase_interferometer_bearing.sv
dv/pib_checker.sv
dv/tb.sv
